// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers shared by the rtl, clocked on clk, reset rst_n
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CCTW_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cctw assertion failed");

// next-cycle implication
`define CCTW_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cctw assertion failed");

`endif

// ===== sv/cctw_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cctw_pkg
// shared types and constants of the coverage cell to waypoint block
// ----------------------------------------------------------------------------
package cctw_pkg;

  // most waypoints one cell can cause: u-turn 2 + row test 3 + column test 3
  localparam int MAX_WP   = 8;
  localparam int IDX_BITS = 3;
  localparam int CNT_BITS = 4;

  typedef enum logic [2:0] {
    DIR_NONE  = 3'd0,
    DIR_UP    = 3'd1,
    DIR_DOWN  = 3'd2,
    DIR_LEFT  = 3'd3,
    DIR_RIGHT = 3'd4
  } dir_t;

  // result of one generation pass
  typedef struct packed {
    logic [CNT_BITS-1:0] count;
    dir_t                dir;
  } gen_status_t;

endpackage
`default_nettype wire

// ===== sv/cctw_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cctw_in_if / cctw_out_if
// valid/ready channels for coarse cells in and fine waypoints out
// ----------------------------------------------------------------------------
interface cctw_in_if #(
  parameter int COARSE_BITS = 8
);
  logic                   valid;
  logic                   ready;
  logic                   path_start;
  logic [COARSE_BITS-1:0] coarse_row;
  logic [COARSE_BITS-1:0] coarse_col;
  logic                   is_leaf;

  modport source (output valid, path_start, coarse_row, coarse_col, is_leaf,
                  input ready);
  modport sink   (input valid, path_start, coarse_row, coarse_col, is_leaf,
                  output ready);
endinterface

interface cctw_out_if #(
  parameter int COARSE_BITS = 8
);
  localparam int FINE_BITS = COARSE_BITS + 1;

  logic                 valid;
  logic                 ready;
  logic [FINE_BITS-1:0] fine_row;
  logic [FINE_BITS-1:0] fine_col;
  logic                 last_of_run;

  modport source (output valid, fine_row, fine_col, last_of_run, input ready);
  modport sink   (input valid, fine_row, fine_col, last_of_run, output ready);
endinterface
`default_nettype wire

// ===== sv/coverage_cell_to_waypoints.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// coverage_cell_to_waypoints
// turns spanning-tree coverage cells into fine-grid corner waypoints
// ----------------------------------------------------------------------------
//
//  channel   dir  payload                                        transfer
//  in_ch     in   path_start, coarse_row, coarse_col, is_leaf    valid & ready
//  out_ch    out  fine_row, fine_col, last_of_run                valid & ready
//
//  a cell is turned into its whole waypoint list (zero to eight entries) in the
//  cycle it is accepted, and the list is loaded into an eight-entry result
//  buffer; the buffer then drains one waypoint per cycle while out_ch is
//  ready. the next cell is taken in the same cycle as the last waypoint of
//  the previous one leaves. cells that cause no waypoint leave the buffer
//  empty and in_ch ready. reset is synchronous, active low, and leaves no
//  previous cell and direction none; out_ch stalls just hold the buffer.
//
module coverage_cell_to_waypoints #(
  parameter int COARSE_BITS = 8
) (
  input wire logic  clk,
  input wire logic  rst_n,
  cctw_in_if.sink   in_ch,
  cctw_out_if.source out_ch
);
  import cctw_pkg::*;

`include "assert_macros.svh"

  localparam int FINE_BITS = COARSE_BITS + 1;

  // previous cell and direction state
  logic [COARSE_BITS-1:0] prev_row_r;
  logic [COARSE_BITS-1:0] prev_col_r;
  logic                   prev_leaf_r;
  logic                   prev_valid_r;
  dir_t                   dir_r;

  // result buffer
  logic [FINE_BITS-1:0]   buf_row_r [MAX_WP];
  logic [FINE_BITS-1:0]   buf_col_r [MAX_WP];
  logic [CNT_BITS-1:0]    cnt_r;
  logic [IDX_BITS-1:0]    idx_r;

  // generator outputs
  logic [FINE_BITS-1:0]   gen_row [MAX_WP];
  logic [FINE_BITS-1:0]   gen_col [MAX_WP];
  gen_status_t            gen_st;

  logic in_xfer;
  logic out_xfer;
  logic at_last;

  // pair is only worked on when a previous cell exists and no new path starts
  cctw_gen #(
    .COARSE_BITS (COARSE_BITS)
  ) u_gen (
    .active    (prev_valid_r && !in_ch.path_start),
    .prev_row  (prev_row_r),
    .prev_col  (prev_col_r),
    .prev_leaf (prev_leaf_r),
    .dir       (dir_r),
    .next_row  (in_ch.coarse_row),
    .next_col  (in_ch.coarse_col),
    .wp_row    (gen_row),
    .wp_col    (gen_col),
    .status    (gen_st)
  );

  // buffer read side
  assign at_last         = (CNT_BITS'({1'b0, idx_r}) + 1'b1) == cnt_r;
  assign out_ch.valid    = cnt_r != '0;
  assign out_ch.fine_row = buf_row_r[idx_r];
  assign out_ch.fine_col = buf_col_r[idx_r];
  assign out_ch.last_of_run = at_last;
  assign out_xfer        = out_ch.valid && out_ch.ready;

  // take a new cell when the buffer is empty or its last waypoint leaves now
  assign in_ch.ready = (cnt_r == '0) || (out_xfer && at_last);
  assign in_xfer     = in_ch.valid && in_ch.ready;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_valid_r <= 1'b0;
      dir_r        <= DIR_NONE;
      cnt_r        <= '0;
      idx_r        <= '0;
    end else begin
      if (in_xfer) begin
        prev_valid_r <= 1'b1;
        dir_r        <= gen_st.dir;
        cnt_r        <= gen_st.count;
        idx_r        <= '0;
      end else if (out_xfer) begin
        if (at_last) begin
          cnt_r <= '0;
          idx_r <= '0;
        end else begin
          idx_r <= idx_r + 1'b1;
        end
      end
    end
  end

  // previous cell payload, reset values only matter once prev_valid_r is set
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_row_r  <= '0;
      prev_col_r  <= '0;
      prev_leaf_r <= 1'b0;
    end else if (in_xfer) begin
      prev_row_r  <= in_ch.coarse_row;
      prev_col_r  <= in_ch.coarse_col;
      prev_leaf_r <= in_ch.is_leaf;
    end
  end

  // waypoint payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      for (int i = 0; i < MAX_WP; i++) begin
        buf_row_r[i] <= gen_row[i];
        buf_col_r[i] <= gen_col[i];
      end
    end
  end

  // read index stays inside the loaded list
  `CCTW_ASSERT_IMPL(a_idx_in_list, out_ch.valid, CNT_BITS'({1'b0, idx_r}) < cnt_r)
  // a new cell never overwrites waypoints still waiting
  `CCTW_ASSERT_IMPL(a_no_overwrite, in_xfer, !out_ch.valid || (out_xfer && at_last))
  // a run only ends on its marked last waypoint
  `CCTW_ASSERT_NEXT(a_run_continues, out_xfer && !at_last, out_ch.valid)
  // list never exceeds the buffer
  `CCTW_ASSERT_IMPL(a_count_fits, 1'b1, cnt_r <= CNT_BITS'(MAX_WP))

endmodule
`default_nettype wire

// ===== sv/cctw_gen.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cctw_gen
// builds the waypoint list for one (previous cell, new cell) pair in one pass
// ----------------------------------------------------------------------------
module cctw_gen #(
  parameter int COARSE_BITS = 8
) (
  input  wire logic                     active,
  input  wire logic [COARSE_BITS-1:0]   prev_row,
  input  wire logic [COARSE_BITS-1:0]   prev_col,
  input  wire logic                     prev_leaf,
  input  wire cctw_pkg::dir_t           dir,
  input  wire logic [COARSE_BITS-1:0]   next_row,
  input  wire logic [COARSE_BITS-1:0]   next_col,
  output logic      [COARSE_BITS:0]     wp_row [cctw_pkg::MAX_WP],
  output logic      [COARSE_BITS:0]     wp_col [cctw_pkg::MAX_WP],
  output cctw_pkg::gen_status_t         status
);
  import cctw_pkg::*;

  localparam int FINE_BITS = COARSE_BITS + 1;

  logic [FINE_BITS-1:0] t, b, l, r;
  logic [FINE_BITS-1:0] er_t, er_b, ec_l, ec_r;
  logic [CNT_BITS-1:0]  n;
  dir_t                 d;

  // corners of the previous cell and of the new cell
  assign t    = {prev_row, 1'b0};
  assign b    = {prev_row, 1'b1};
  assign l    = {prev_col, 1'b0};
  assign r    = {prev_col, 1'b1};
  assign er_t = {next_row, 1'b0};
  assign er_b = {next_row, 1'b1};
  assign ec_l = {next_col, 1'b0};
  assign ec_r = {next_col, 1'b1};

  always_comb begin
    for (int i = 0; i < MAX_WP; i++) begin
      wp_row[i] = '0;
      wp_col[i] = '0;
    end
    n = '0;
    d = dir;

    if (!active) begin
      d = DIR_NONE;
    end else begin
      // u-turn around a leaf cell
      if (prev_leaf) begin
        if (d == DIR_UP) begin
          wp_row[n[IDX_BITS-1:0]] = t; wp_col[n[IDX_BITS-1:0]] = l; n = n + 1'b1;
          wp_row[n[IDX_BITS-1:0]] = t; wp_col[n[IDX_BITS-1:0]] = r; n = n + 1'b1;
        end else if (d == DIR_DOWN) begin
          wp_row[n[IDX_BITS-1:0]] = b; wp_col[n[IDX_BITS-1:0]] = r; n = n + 1'b1;
          wp_row[n[IDX_BITS-1:0]] = b; wp_col[n[IDX_BITS-1:0]] = l; n = n + 1'b1;
        end else if (d == DIR_LEFT) begin
          wp_row[n[IDX_BITS-1:0]] = b; wp_col[n[IDX_BITS-1:0]] = l; n = n + 1'b1;
          wp_row[n[IDX_BITS-1:0]] = t; wp_col[n[IDX_BITS-1:0]] = l; n = n + 1'b1;
        end else if (d == DIR_RIGHT) begin
          wp_row[n[IDX_BITS-1:0]] = t; wp_col[n[IDX_BITS-1:0]] = r; n = n + 1'b1;
          wp_row[n[IDX_BITS-1:0]] = b; wp_col[n[IDX_BITS-1:0]] = r; n = n + 1'b1;
        end
      end

      // up: ends at bl of the new cell
      if (prev_row > next_row) begin
        if (d == DIR_RIGHT) begin
          wp_row[n[IDX_BITS-1:0]] = er_b; wp_col[n[IDX_BITS-1:0]] = ec_l; n = n + 1'b1;
        end else if (d != DIR_LEFT) begin
          wp_row[n[IDX_BITS-1:0]] = b; wp_col[n[IDX_BITS-1:0]] = l; n = n + 1'b1;
          wp_row[n[IDX_BITS-1:0]] = t; wp_col[n[IDX_BITS-1:0]] = l; n = n + 1'b1;
          wp_row[n[IDX_BITS-1:0]] = er_b; wp_col[n[IDX_BITS-1:0]] = ec_l; n = n + 1'b1;
        end else begin
          wp_row[n[IDX_BITS-1:0]] = t; wp_col[n[IDX_BITS-1:0]] = l; n = n + 1'b1;
          wp_row[n[IDX_BITS-1:0]] = er_b; wp_col[n[IDX_BITS-1:0]] = ec_l; n = n + 1'b1;
        end
        d = DIR_UP;
      end

      // down: ends at tr of the new cell
      if (prev_row < next_row) begin
        if (d == DIR_LEFT) begin
          wp_row[n[IDX_BITS-1:0]] = er_t; wp_col[n[IDX_BITS-1:0]] = ec_r; n = n + 1'b1;
        end else if (d == DIR_RIGHT) begin
          wp_row[n[IDX_BITS-1:0]] = t; wp_col[n[IDX_BITS-1:0]] = r; n = n + 1'b1;
          wp_row[n[IDX_BITS-1:0]] = b; wp_col[n[IDX_BITS-1:0]] = r; n = n + 1'b1;
          wp_row[n[IDX_BITS-1:0]] = er_t; wp_col[n[IDX_BITS-1:0]] = ec_r; n = n + 1'b1;
        end else begin
          wp_row[n[IDX_BITS-1:0]] = b; wp_col[n[IDX_BITS-1:0]] = r; n = n + 1'b1;
          wp_row[n[IDX_BITS-1:0]] = er_t; wp_col[n[IDX_BITS-1:0]] = ec_r; n = n + 1'b1;
        end
        d = DIR_DOWN;
      end

      // right: ends at tl of the new cell
      if (prev_col < next_col) begin
        if (d == DIR_DOWN) begin
          wp_row[n[IDX_BITS-1:0]] = er_t; wp_col[n[IDX_BITS-1:0]] = ec_l; n = n + 1'b1;
        end else if (d == DIR_UP) begin
          wp_row[n[IDX_BITS-1:0]] = t; wp_col[n[IDX_BITS-1:0]] = l; n = n + 1'b1;
          wp_row[n[IDX_BITS-1:0]] = t; wp_col[n[IDX_BITS-1:0]] = r; n = n + 1'b1;
          wp_row[n[IDX_BITS-1:0]] = er_t; wp_col[n[IDX_BITS-1:0]] = ec_l; n = n + 1'b1;
        end else begin
          wp_row[n[IDX_BITS-1:0]] = t; wp_col[n[IDX_BITS-1:0]] = r; n = n + 1'b1;
          wp_row[n[IDX_BITS-1:0]] = er_t; wp_col[n[IDX_BITS-1:0]] = ec_l; n = n + 1'b1;
        end
        d = DIR_RIGHT;
      end

      // left: ends at br of the new cell
      if (prev_col > next_col) begin
        if (d == DIR_DOWN) begin
          wp_row[n[IDX_BITS-1:0]] = b; wp_col[n[IDX_BITS-1:0]] = r; n = n + 1'b1;
          wp_row[n[IDX_BITS-1:0]] = b; wp_col[n[IDX_BITS-1:0]] = l; n = n + 1'b1;
          wp_row[n[IDX_BITS-1:0]] = er_b; wp_col[n[IDX_BITS-1:0]] = ec_r; n = n + 1'b1;
        end else if (d == DIR_UP) begin
          wp_row[n[IDX_BITS-1:0]] = er_b; wp_col[n[IDX_BITS-1:0]] = ec_r; n = n + 1'b1;
        end else begin
          wp_row[n[IDX_BITS-1:0]] = b; wp_col[n[IDX_BITS-1:0]] = l; n = n + 1'b1;
          wp_row[n[IDX_BITS-1:0]] = er_b; wp_col[n[IDX_BITS-1:0]] = ec_r; n = n + 1'b1;
        end
        d = DIR_LEFT;
      end
    end

    status.count = n;
    status.dir   = d;
  end

endmodule
`default_nettype wire

// ===== tb/coverage_cell_to_waypoints_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// coverage_cell_to_waypoints_tb
// self-checking bench for the coverage cell to fine waypoint generator
//
// coarse cells go in on in_ch, fine-grid corners come out on out_ch. a
// predictor in the bench tracks the previous cell, its leaf flag and the
// move direction, and queues the corners each accepted cell should cause.
// every out_ch transfer is checked against the oldest queued corner. a
// short table of directed cells runs first, then random coverage paths
// with some noise, random idling on both sides, a long output hold-off
// and a full drain pause.
// ----------------------------------------------------------------------------
module coverage_cell_to_waypoints_tb;
  import cctw_pkg::*;

  localparam int CB        = 8;
  localparam int FB        = CB + 1;
  localparam int HOLD_LEN  = 150;   // cycles of the long output hold-off
  localparam int TAIL_LEN  = 16;    // quiet cycles after the last corner
  localparam int N_TABLE   = 23;
  localparam int N_FIXED   = 5;
  localparam int MAX_SHOWN = 10;

  typedef struct packed {
    logic          path_start;
    logic [CB-1:0] coarse_row;
    logic [CB-1:0] coarse_col;
    logic          is_leaf;
  } cell_t;

  typedef struct packed {
    logic [FB-1:0] fine_row;
    logic [FB-1:0] fine_col;
    logic          last_of_run;
  } waypoint_t;

  // directed row: the cell, and how many hand-written corners it expects
  // (-1 means the predictor decides)
  typedef struct {
    logic          start;
    logic [CB-1:0] row;
    logic [CB-1:0] col;
    logic          leaf;
    int            fixed_n;
  } table_row_t;

  logic clk = 1'b0;
  logic rst_n;

  cctw_in_if  #(.COARSE_BITS(CB)) in_ch ();
  cctw_out_if #(.COARSE_BITS(CB)) out_ch ();

  coverage_cell_to_waypoints #(.COARSE_BITS(CB)) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // predictor state: previous cell and direction of travel
  // --------------------------------------------------------------------------
  logic [CB-1:0] pv_row;
  logic [CB-1:0] pv_col;
  logic          pv_leaf;
  logic          pv_valid;
  dir_t          mv_dir;

  waypoint_t new_wps [$];        // corners of the cell just accepted
  waypoint_t waypoints_due [$];  // corners still to come out of the block

  int  n_errors     = 0;
  int  n_cells      = 0;
  int  n_checked    = 0;
  int  n_full_cells = 0;
  int  fixed_idx    = 0;
  bit  no_idle      = 1'b0;      // both sides run without gaps
  bit  hold_req     = 1'b0;      // ask the receiver for a long hold-off

  // corners typed in for the directed rows, consumed in table order
  waypoint_t fixed_wps [N_FIXED] = '{
    // right step from direction none: tr of (0,0), tl of (0,1)
    {9'd0,   9'd1,   1'b0},
    {9'd0,   9'd2,   1'b1},
    // up step at the far corner of the grid
    {9'd511, 9'd510, 1'b0},
    {9'd510, 9'd510, 1'b0},
    {9'd509, 9'd510, 1'b1}
  };

  table_row_t cell_table [N_TABLE] = '{
    '{1'b0, 8'd0,   8'd0,   1'b0,  0},  // no previous cell after reset
    '{1'b0, 8'd0,   8'd0,   1'b0,  0},  // same cell, not a leaf
    '{1'b0, 8'd0,   8'd1,   1'b0,  2},  // right, direction none
    '{1'b1, 8'd255, 8'd255, 1'b1,  0},  // new path at the top extreme
    '{1'b0, 8'd254, 8'd255, 1'b0,  3},  // leaf u-turn with no direction
    '{1'b0, 8'd254, 8'd254, 1'b0, -1},  // left after up
    '{1'b0, 8'd254, 8'd254, 1'b1, -1},  // same cell, becomes a leaf
    '{1'b0, 8'd254, 8'd254, 1'b0, -1},  // same cell, u-turn going left
    '{1'b0, 8'd255, 8'd255, 1'b1, -1},  // diagonal down-right
    '{1'b0, 8'd254, 8'd254, 1'b0, -1},  // u-turn right, diagonal up-left
    '{1'b1, 8'd0,   8'd0,   1'b0,  0},  // new path at the origin
    '{1'b0, 8'd1,   8'd1,   1'b0, -1},  // diagonal down-right from none
    '{1'b0, 8'd0,   8'd2,   1'b1, -1},  // diagonal up-right
    '{1'b0, 8'd1,   8'd1,   1'b0, -1},  // u-turn + down + left: eight corners
    '{1'b0, 8'd0,   8'd1,   1'b1, -1},  // up
    '{1'b0, 8'd0,   8'd1,   1'b0, -1},  // same cell, u-turn going up
    '{1'b0, 8'd1,   8'd1,   1'b1, -1},  // down
    '{1'b0, 8'd1,   8'd1,   1'b0, -1},  // same cell, u-turn going down
    '{1'b0, 8'd1,   8'd0,   1'b0, -1},  // left
    '{1'b0, 8'd0,   8'd0,   1'b0, -1},  // up after left
    '{1'b0, 8'd1,   8'd1,   1'b1, -1},  // diagonal down-right after up
    '{1'b0, 8'd0,   8'd255, 1'b0, -1},  // long jump up-right
    '{1'b1, 8'd128, 8'd0,   1'b1,  0}   // new path in the middle of one
  };

  // --------------------------------------------------------------------------
  // waypoint predictor
  // --------------------------------------------------------------------------
  function void add_corner(input logic [FB-1:0] r, input logic [FB-1:0] c);
    if (new_wps.size() < MAX_WP)
      new_wps.insert(new_wps.size(), {r, c, 1'b0});
  endfunction

  function void plan_waypoints(input cell_t cl);
    logic [FB-1:0] t, b, l, r, er, ec;
    dir_t          d;
    new_wps.delete();
    if (cl.path_start || !pv_valid) begin
      // a path start, or the first cell ever: just remember it
      mv_dir = DIR_NONE;
    end else begin
      t = {pv_row, 1'b0};
      b = {pv_row, 1'b1};
      l = {pv_col, 1'b0};
      r = {pv_col, 1'b1};
      d = mv_dir;
      // leaving a leaf: turn around inside it first
      if (pv_leaf) begin
        case (d)
          DIR_UP: begin
            add_corner(t, l); add_corner(t, r);
          end
          DIR_DOWN: begin
            add_corner(b, r); add_corner(b, l);
          end
          DIR_LEFT: begin
            add_corner(b, l); add_corner(t, l);
          end
          DIR_RIGHT: begin
            add_corner(t, r); add_corner(b, r);
          end
          default: ;
        endcase
      end
      // up: ends on bl of the next cell
      if (pv_row > cl.coarse_row) begin
        er = {cl.coarse_row, 1'b1};
        ec = {cl.coarse_col, 1'b0};
        if (d == DIR_RIGHT) begin
          add_corner(er, ec);
        end else if (d != DIR_LEFT) begin
          add_corner(b, l); add_corner(t, l); add_corner(er, ec);
        end else begin
          add_corner(t, l); add_corner(er, ec);
        end
        d = DIR_UP;
      end
      // down: ends on tr of the next cell
      if (pv_row < cl.coarse_row) begin
        er = {cl.coarse_row, 1'b0};
        ec = {cl.coarse_col, 1'b1};
        if (d == DIR_LEFT) begin
          add_corner(er, ec);
        end else if (d == DIR_RIGHT) begin
          add_corner(t, r); add_corner(b, r); add_corner(er, ec);
        end else begin
          add_corner(b, r); add_corner(er, ec);
        end
        d = DIR_DOWN;
      end
      // right: ends on tl of the next cell
      if (pv_col < cl.coarse_col) begin
        er = {cl.coarse_row, 1'b0};
        ec = {cl.coarse_col, 1'b0};
        if (d == DIR_DOWN) begin
          add_corner(er, ec);
        end else if (d == DIR_UP) begin
          add_corner(t, l); add_corner(t, r); add_corner(er, ec);
        end else begin
          add_corner(t, r); add_corner(er, ec);
        end
        d = DIR_RIGHT;
      end
      // left: ends on br of the next cell
      if (pv_col > cl.coarse_col) begin
        er = {cl.coarse_row, 1'b1};
        ec = {cl.coarse_col, 1'b1};
        if (d == DIR_DOWN) begin
          add_corner(b, r); add_corner(b, l); add_corner(er, ec);
        end else if (d == DIR_UP) begin
          add_corner(er, ec);
        end else begin
          add_corner(b, l); add_corner(er, ec);
        end
        d = DIR_LEFT;
      end
      mv_dir = d;
    end
    pv_row   = cl.coarse_row;
    pv_col   = cl.coarse_col;
    pv_leaf  = cl.is_leaf;
    pv_valid = 1'b1;
    if (new_wps.size() > 0)
      new_wps[new_wps.size() - 1].last_of_run = 1'b1;
  endfunction

  function int draw_gap();
    return no_idle ? 0 : $urandom_range(0, 12);
  endfunction

  // --------------------------------------------------------------------------
  // sender: called at a falling edge, returns at the falling edge after the
  // transfer with valid still high, so back-to-back cells never glitch it
  // --------------------------------------------------------------------------
  task automatic offer_cell(input cell_t cl, input int fixed_n);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.path_start = cl.path_start;
    in_ch.coarse_row = cl.coarse_row;
    in_ch.coarse_col = cl.coarse_col;
    in_ch.is_leaf    = cl.is_leaf;
    in_ch.valid      = 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    // transfer taken: predict, then queue typed or predicted corners
    plan_waypoints(cl);
    n_cells++;
    if (new_wps.size() == MAX_WP)
      n_full_cells++;
    if (fixed_n >= 0) begin
      for (int k = 0; k < fixed_n; k++)
        waypoints_due.insert(waypoints_due.size(), fixed_wps[fixed_idx + k]);
      fixed_idx += fixed_n;
    end else begin
      foreach (new_wps[k])
        waypoints_due.insert(waypoints_due.size(), new_wps[k]);
    end
    @(negedge clk);
  endtask

  // drop valid and wait for the block to hand back everything owed
  task automatic drain_all();
    in_ch.valid = 1'b0;
    while (waypoints_due.size() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  // step a coordinate by -1, 0 or +1, bouncing off the grid edges
  function logic [CB-1:0] nudge(input logic [CB-1:0] v, input int d);
    if (d < 0 && v == '0)
      return v + 1'b1;
    if (d > 0 && v == '1)
      return v - 1'b1;
    return v + d[CB-1:0];
  endfunction

  // start cells lean toward the grid edges
  function logic [CB-1:0] pick_coord();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return CB'($urandom);
    endcase
  endfunction

  // mostly coherent paths (start then walk), some raw noise cells
  task automatic send_random(input int n);
    int    sent;
    int    len;
    int    kind;
    int    dr;
    int    dc;
    cell_t cl;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(0, 99) < 85) begin
        cl.path_start = 1'b1;
        cl.coarse_row = pick_coord();
        cl.coarse_col = pick_coord();
        cl.is_leaf    = ($urandom_range(0, 2) == 0);
        offer_cell(cl, -1);
        sent++;
        len = $urandom_range(4, 24);
        for (int k = 0; k < len && sent < n; k++) begin
          kind          = $urandom_range(0, 9);
          dr            = 0;
          dc            = 0;
          cl.path_start = 1'b0;
          if (kind == 9) begin
            // long jump anywhere on the grid
            cl.coarse_row = CB'($urandom);
            cl.coarse_col = CB'($urandom);
          end else begin
            if (kind >= 1 && kind <= 6) begin
              if ($urandom_range(0, 1))
                dr = $urandom_range(0, 1) ? 1 : -1;
              else
                dc = $urandom_range(0, 1) ? 1 : -1;
            end else if (kind >= 7) begin
              dr = $urandom_range(0, 1) ? 1 : -1;
              dc = $urandom_range(0, 1) ? 1 : -1;
            end
            // kind 0 repeats the cell
            cl.coarse_row = nudge(cl.coarse_row, dr);
            cl.coarse_col = nudge(cl.coarse_col, dc);
          end
          cl.is_leaf = ($urandom_range(0, 2) == 0);
          offer_cell(cl, -1);
          sent++;
        end
      end else begin
        len = $urandom_range(1, 6);
        for (int k = 0; k < len && sent < n; k++) begin
          cl = cell_t'($urandom);
          offer_cell(cl, -1);
          sent++;
        end
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // receiver and checker
  // --------------------------------------------------------------------------
  initial begin
    int        stall;
    waypoint_t got;
    waypoint_t want;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        // long hold-off so the result buffer fills and in_ch backs up
        out_ch.ready = 1'b0;
        repeat (HOLD_LEN) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        stall = draw_gap();
        if (stall > 0) begin
          out_ch.ready = 1'b0;
          repeat (stall) @(negedge clk);
        end
      end
      out_ch.ready = 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      got = {out_ch.fine_row, out_ch.fine_col, out_ch.last_of_run};
      if (waypoints_due.size() == 0) begin
        n_errors++;
        if (n_errors <= MAX_SHOWN)
          $display("%0t: unexpected waypoint row %0d col %0d last %0b",
                   $time, got.fine_row, got.fine_col, got.last_of_run);
      end else begin
        want = waypoints_due.pop_front();
        n_checked++;
        if (got.fine_row !== want.fine_row || got.fine_col !== want.fine_col ||
            got.last_of_run !== want.last_of_run) begin
          n_errors++;
          if (n_errors <= MAX_SHOWN)
            $display("%0t: mismatch: want %0d/%0d/%0b, got %0d/%0d/%0b",
                     $time, want.fine_row, want.fine_col, want.last_of_run,
                     got.fine_row, got.fine_col, got.last_of_run);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus sequence
  // --------------------------------------------------------------------------
  initial begin
    cell_t cl;
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.path_start = 1'b0;
    in_ch.coarse_row = '0;
    in_ch.coarse_col = '0;
    in_ch.is_leaf    = 1'b0;
    pv_row           = '0;
    pv_col           = '0;
    pv_leaf          = 1'b0;
    pv_valid         = 1'b0;
    mv_dir           = DIR_NONE;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed table
    foreach (cell_table[i]) begin
      cl = {cell_table[i].start, cell_table[i].row, cell_table[i].col,
            cell_table[i].leaf};
      offer_cell(cl, cell_table[i].fixed_n);
    end

    send_random(140);

    // output held off while cells keep coming with no gaps
    no_idle  = 1'b1;
    hold_req = 1'b1;
    send_random(40);
    no_idle  = 1'b0;

    // sender pauses until every owed corner is out
    drain_all();
    send_random(120);

    // a stretch with no idling on either side
    no_idle = 1'b1;
    send_random(60);
    no_idle = 1'b0;
    send_random(60);

    drain_all();
    repeat (TAIL_LEN) @(posedge clk);

    $display("ran %0d cells, checked %0d waypoints", n_cells, n_checked);
    $display("%0d cells caused the full eight corners", n_full_cells);
    if (n_errors == 0 && waypoints_due.size() == 0) begin
      $display("[coverage_cell_to_waypoints] OK");
    end else begin
      $display("%0d errors, %0d waypoints never seen", n_errors, waypoints_due.size());
      $display("[coverage_cell_to_waypoints] ERROR");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #5000000;
    $display("timeout with %0d waypoints outstanding", waypoints_due.size());
    $display("[coverage_cell_to_waypoints] ERROR");
    $finish;
  end

endmodule
